// ===== rtl/core/atsc_pkg.sv =====
// Shared types and constants for the assembly token scanner.
`default_nettype none

package atsc_pkg;

   // Default saturation limit of the identifier and number length counter.
   localparam int unsigned MAX_LEN_DEFAULT = 63;

   // Result queue geometry.
   localparam int unsigned RSPQ_DEPTH = 4;
   localparam int unsigned RSPQ_AW    = $clog2(RSPQ_DEPTH);

   // Largest number or register value; larger values saturate here.
   localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

   // Token kinds carried on the result channel.
   typedef enum logic [2:0] {
      KIND_END     = 3'd0,
      KIND_NEWLINE = 3'd1,
      KIND_COLON   = 3'd2,
      KIND_COMMA   = 3'd3,
      KIND_NUMBER  = 3'd4,
      KIND_IDENT   = 3'd5,
      KIND_REG     = 3'd6,
      KIND_ICHAR   = 3'd7
   } kind_type;

   // Scanner mode.
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_NUM   = 2'd1,
      MODE_IDENT = 2'd2
   } mode_type;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [30:0] value;
      logic [7:0]  text_char;
      logic [5:0]  text_length;
      logic [15:0] line_number;
      logic        overflow;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/atsc_step.sv =====
// Combinational scan step: classifies one character and updates the token state.
`default_nettype none

module atsc_step
   import atsc_pkg::*;
#(
   parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT,
   parameter int unsigned LEN_W   = $clog2(MAX_LEN + 1)
) (
   input  wire logic [7:0]       ch,
   input  wire mode_type         mode,
   input  wire logic [30:0]      accum,
   input  wire logic [LEN_W-1:0] token_len,
   input  wire logic [2:0]       reg_flags,
   input  wire logic [15:0]      line_count,
   input  wire logic             saturated,
   output mode_type              mode_nxt,
   output logic [30:0]           accum_nxt,
   output logic [LEN_W-1:0]      token_len_nxt,
   output logic [2:0]            reg_flags_nxt,
   output logic [15:0]           line_count_nxt,
   output logic                  saturated_nxt,
   output logic                  res0_valid,
   output rsp_type               res0,
   output logic                  res1_valid,
   output rsp_type               res1
);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam int unsigned CMP_W   = (LEN_W > 6) ? LEN_W : 6;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

   // Multiply by ten and add a digit, saturating; the top bit flags saturation.
   function automatic logic [31:0] mac10(input logic [30:0] acc, input logic [3:0] dig);
      logic [34:0] prod;
      begin
         prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, dig};
         if (prod > {4'd0, VALUE_MAX}) begin
            mac10 = {1'b1, VALUE_MAX};
         end else begin
            mac10 = {1'b0, prod[30:0]};
         end
      end
   endfunction

   // Clamp the internal length to the six-bit field.
   function automatic logic [5:0] shown_len(input logic [LEN_W-1:0] len);
      logic [CMP_W-1:0] wide;
      begin
         wide = CMP_W'(len);
         if (wide > CMP_W'(63)) begin
            shown_len = 6'd63;
         end else begin
            shown_len = wide[5:0];
         end
      end
   endfunction

   // Build a result item.
   function automatic rsp_type make_rsp(input kind_type kind, input logic [30:0] value,
                                        input logic [7:0] tc, input logic [5:0] len,
                                        input logic [15:0] line, input logic ovf);
      rsp_type r;
      begin
         r.kind        = kind;
         r.value       = value;
         r.text_char   = tc;
         r.text_length = len;
         r.line_number = line;
         r.overflow    = ovf;
         r.last        = 1'b0;
         make_rsp      = r;
      end
   endfunction

   logic       is_digit;
   logic       is_alpha;
   logic       is_word;
   logic [3:0] digit;

   // Character classes.
   always_comb begin
      is_digit = (ch >= 8'h30) && (ch <= 8'h39);
      is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
      is_word  = is_alpha || is_digit || (ch == CH_UNDER);
      digit    = ch[3:0];
   end

   // Close or extend the pending token; after closing it, treat the character as fresh.
   always_comb begin
      logic        done;
      logic        have0;
      logic        second;
      logic [31:0] acc_sum;
      rsp_type     fresh;
      logic        fresh_valid;

      mode_nxt       = mode;
      accum_nxt      = accum;
      token_len_nxt  = token_len;
      reg_flags_nxt  = reg_flags;
      line_count_nxt = line_count;
      saturated_nxt  = saturated;
      res0           = make_rsp(KIND_END, '0, '0, '0, line_count, 1'b0);
      res1           = res0;
      res0_valid     = 1'b0;
      res1_valid     = 1'b0;
      done           = 1'b0;
      have0          = 1'b0;
      second         = (token_len == LEN_ONE);
      acc_sum        = mac10(accum, digit);
      fresh          = res0;
      fresh_valid    = 1'b0;

      // Pending token: extend it or emit its closing result.
      unique case (mode)
         MODE_NUM: begin
            if (is_digit) begin
               accum_nxt = acc_sum[30:0];
               saturated_nxt = saturated | acc_sum[31];
               if (token_len >= LEN_LIMIT) begin
                  token_len_nxt = LEN_LIMIT;
                  saturated_nxt = 1'b1;
               end else begin
                  token_len_nxt = token_len + LEN_ONE;
               end
               done = 1'b1;
            end else begin
               res0 = make_rsp(KIND_NUMBER, accum, '0, shown_len(token_len),
                               line_count, saturated);
               have0 = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_word) begin
               if (token_len >= LEN_LIMIT) begin
                  token_len_nxt = LEN_LIMIT;
                  saturated_nxt = 1'b1;
               end else begin
                  token_len_nxt = token_len + LEN_ONE;
               end
               if (second) begin
                  if (reg_flags[0] && is_digit) begin
                     reg_flags_nxt = reg_flags | 3'b110;
                     accum_nxt     = {27'd0, digit};
                  end
               end else if (reg_flags[2]) begin
                  if (is_digit) begin
                     accum_nxt     = acc_sum[30:0];
                     saturated_nxt = saturated_nxt | acc_sum[31];
                  end else begin
                     reg_flags_nxt = reg_flags & 3'b011;
                  end
               end
               res0 = make_rsp(KIND_ICHAR, '0, ch, shown_len(token_len_nxt),
                               line_count, saturated_nxt);
               res0.last  = 1'b1;
               res0_valid = 1'b1;
               done       = 1'b1;
            end else begin
               if (reg_flags[1]) begin
                  res0 = make_rsp(KIND_REG, accum, '0, shown_len(token_len),
                                  line_count, saturated);
               end else begin
                  res0 = make_rsp(KIND_IDENT, '0, '0, shown_len(token_len),
                                  line_count, saturated);
               end
               have0 = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Fresh character with the token state cleared.
      if (!done) begin
         mode_nxt      = MODE_IDLE;
         accum_nxt     = '0;
         token_len_nxt = '0;
         reg_flags_nxt = '0;
         saturated_nxt = 1'b0;
         priority if (ch == CH_NUL) begin
            fresh_valid = 1'b1;
         end else if (ch == CH_LF) begin
            fresh       = make_rsp(KIND_NEWLINE, '0, '0, '0, line_count, 1'b0);
            fresh_valid = 1'b1;
            if (line_count != 16'hFFFF) begin
               line_count_nxt = line_count + 16'd1;
            end
         end else if (ch == CH_COLON) begin
            fresh       = make_rsp(KIND_COLON, '0, '0, '0, line_count, 1'b0);
            fresh_valid = 1'b1;
         end else if (ch == CH_COMMA) begin
            fresh       = make_rsp(KIND_COMMA, '0, '0, '0, line_count, 1'b0);
            fresh_valid = 1'b1;
         end else if (is_digit) begin
            mode_nxt      = MODE_NUM;
            accum_nxt     = {27'd0, digit};
            token_len_nxt = LEN_ONE;
         end else if (is_word) begin
            mode_nxt         = MODE_IDENT;
            token_len_nxt    = LEN_ONE;
            reg_flags_nxt[0] = (ch == CH_R);
            fresh            = make_rsp(KIND_ICHAR, '0, ch, 6'd1, line_count, 1'b0);
            fresh_valid      = 1'b1;
         end else if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR)) begin
            fresh_valid = 1'b0;
         end else begin
            fresh_valid = 1'b0;
         end
         fresh.last = 1'b1;

         // Pack the results so that the first valid one sits in slot zero.
         if (have0) begin
            res0_valid = 1'b1;
            res0.last  = !fresh_valid;
            res1       = fresh;
            res1_valid = fresh_valid;
         end else begin
            res0       = fresh;
            res0_valid = fresh_valid;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/atsc_rsp_queue.sv =====
// Result queue: takes up to two results a cycle and hands out one.
`default_nettype none

module atsc_rsp_queue
   import atsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push0,
   input  wire rsp_type data0,
   input  wire logic    push1,
   input  wire rsp_type data1,
   output logic         room2,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_ready
);

   rsp_type            entry_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0] wr_ptr_ff;
   logic [RSPQ_AW-1:0] wr_ptr_in;
   logic [RSPQ_AW-1:0] rd_ptr_ff;
   logic [RSPQ_AW-1:0] rd_ptr_in;
   logic [RSPQ_AW:0]   count_ff;
   logic [RSPQ_AW:0]   count_in;
   logic               pop;
   logic [RSPQ_AW:0]   push_cnt;

   // Pointer and fill count bookkeeping.
   always_comb begin
      pop       = out_valid && out_ready;
      push_cnt  = (RSPQ_AW + 1)'(push0) + (RSPQ_AW + 1)'(push1);
      wr_ptr_in = wr_ptr_ff + push_cnt[RSPQ_AW-1:0];
      rd_ptr_in = rd_ptr_ff + RSPQ_AW'(pop);
      count_in  = count_ff + push_cnt - (RSPQ_AW + 1)'(pop);
      room2     = count_ff <= (RSPQ_AW + 1)'(RSPQ_DEPTH - 2);
      out_valid = count_ff != '0;
      out_data  = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; slot one only follows slot zero.
   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         entry_ff[wr_ptr_ff + RSPQ_AW'(1)] <= data1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/assembly_token_scanner_core.sv =====
// Top level of the assembly token scanner: input register, scan state and result queue.
//
// The block takes one source byte per request on the req_ channel and returns
// tokens on the rsp_ channel, both with valid/ready handshakes. A request may
// cause zero, one or two results; rsp_last marks the final result of a request.
// A request is captured in an input register, scanned once the queue has room
// by a single combinational step, and its results enter a four-entry queue.
// Results pass through the input register and then the queue registers before
// they show on the rsp_ ports. Throughput is one request per cycle while the
// queue has room for two results; it is limited only by the result port,
// which delivers one result per cycle, so requests yielding two results are
// paced by the queue draining. When the receiver stalls, the queue fills, and
// req_ready drops once fewer than two entries are free while a request waits
// in the input register; nothing is lost. Synchronous reset empties the input
// register and queue, clears the scan state and sets the line counter to one.
`default_nettype none

module assembly_token_scanner_core
   import atsc_pkg::*;
#(
   parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [30:0]      rsp_value,
   output logic [7:0]       rsp_text_char,
   output logic [5:0]       rsp_text_length,
   output logic [15:0]      rsp_line_number,
   output logic             rsp_overflow,
   output logic             rsp_last
);

   localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_ch_ff;
   logic             step_fire;
   logic             room2;

   mode_type         mode_ff;
   mode_type         mode_in;
   logic [30:0]      accum_ff;
   logic [30:0]      accum_in;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [2:0]       flags_ff;
   logic [2:0]       flags_in;
   logic [15:0]      line_ff;
   logic [15:0]      line_in;
   logic             sat_ff;
   logic             sat_in;

   logic             res0_valid;
   rsp_type          res0;
   logic             res1_valid;
   rsp_type          res1;
   rsp_type          out_data;

   // Input register advances whenever the queue has room for a full request.
   always_comb begin
      step_fire   = in_valid_ff && room2;
      req_ready   = !in_valid_ff || room2;
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         accum_ff <= '0;
         len_ff   <= '0;
         flags_ff <= '0;
         line_ff  <= 16'd1;
         sat_ff   <= 1'b0;
      end else if (step_fire) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         len_ff   <= len_in;
         flags_ff <= flags_in;
         line_ff  <= line_in;
         sat_ff   <= sat_in;
      end
   end

   atsc_step #(
      .MAX_LEN (MAX_LEN),
      .LEN_W   (LEN_W)
   ) u_step (
      .ch             (in_ch_ff),
      .mode           (mode_ff),
      .accum          (accum_ff),
      .token_len      (len_ff),
      .reg_flags      (flags_ff),
      .line_count     (line_ff),
      .saturated      (sat_ff),
      .mode_nxt       (mode_in),
      .accum_nxt      (accum_in),
      .token_len_nxt  (len_in),
      .reg_flags_nxt  (flags_in),
      .line_count_nxt (line_in),
      .saturated_nxt  (sat_in),
      .res0_valid     (res0_valid),
      .res0           (res0),
      .res1_valid     (res1_valid),
      .res1           (res1)
   );

   atsc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (step_fire && res0_valid),
      .data0     (res0),
      .push1     (step_fire && res1_valid),
      .data1     (res1),
      .room2     (room2),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_ready (rsp_ready)
   );

   // Result fields.
   always_comb begin
      rsp_kind        = out_data.kind;
      rsp_value       = out_data.value;
      rsp_text_char   = out_data.text_char;
      rsp_text_length = out_data.text_length;
      rsp_line_number = out_data.line_number;
      rsp_overflow    = out_data.overflow;
      rsp_last        = out_data.last;
   end

endmodule

`default_nettype wire
